// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

  // screen geometry
  localparam int unsigned COLUMNS        = 80;
  localparam int unsigned ROWS           = 25;
  localparam int unsigned CELLS          = COLUMNS * ROWS;
  localparam int unsigned LAST_ROW_START = (ROWS - 1) * COLUMNS;

  // widths
  localparam int unsigned ADDR_W    = $clog2(CELLS);
  localparam int unsigned CUR_W     = $clog2(CELLS + 4);
  localparam int unsigned COL_W     = $clog2(COLUMNS);
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COLOUR_W  = 4;
  localparam int unsigned ATTR_W    = 2 * COLOUR_W;
  localparam int unsigned CELL_W    = ATTR_W + CHAR_W;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

  // colours after reset
  localparam logic [COLOUR_W-1:0] FG_RESET   = 4'hF;
  localparam logic [COLOUR_W-1:0] BG_RESET   = 4'h0;
  localparam logic [CELL_W-1:0]   RESET_CELL = {BG_RESET, FG_RESET, CH_SPACE};

  typedef enum logic {
    OP_PUT   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    STEP_INC      = 2'd0,
    STEP_DEC      = 2'd1,
    STEP_ADD_COLS = 2'd2,
    STEP_ADD_FOUR = 2'd3
  } step_kind_e;

  typedef struct packed {
    step_kind_e       kind;
    logic [CUR_W-1:0] operand;
  } step_req_t;

  typedef struct packed {
    logic              op_clear;
    logic [CHAR_W-1:0] char_code;
    logic              eos;
  } item_t;

  typedef struct packed {
    logic [CUR_W-1:0] cursor;
    logic             update;
    logic             scrolled;
  } result_t;

endpackage

// ----- rtl/core/tcw_step_unit.sv -----
module tcw_step_unit
  import tcw_pkg::*;
(
  input  step_req_t        req_i,
  output logic [CUR_W-1:0] sum_o
);

  logic [CUR_W-1:0] addend;

  always_comb begin
    case (req_i.kind)
      STEP_INC:      addend = CUR_W'(1);
      STEP_DEC:      addend = '1;
      STEP_ADD_COLS: addend = CUR_W'(COLUMNS);
      STEP_ADD_FOUR: addend = CUR_W'(4);
      default:       addend = '0;
    endcase
  end

  assign sum_o = req_i.operand + addend;

endmodule

// ----- rtl/core/tcw_sequencer.sv -----
module tcw_sequencer
  import tcw_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              item_ready_o,
  input  logic [ATTR_W-1:0] attr_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output result_t           res_o
);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_TAB   = 7'b0001000,
    ST_COPY  = 7'b0010000,
    ST_BLANK = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_e;

  localparam logic [CUR_W-1:0] ALIGN4_MASK = ~(CUR_W'(3));

  state_e            state_q, state_d;
  logic [CUR_W-1:0]  cursor_q, cursor_d;
  logic [CUR_W-1:0]  row_start_q, row_start_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CUR_W-1:0]  sweep_q, sweep_d;
  logic [CUR_W-1:0]  stop_q, stop_d;
  item_t             item_q, item_d;
  logic              pend_q, pend_d;
  logic              upd_q, upd_d;
  logic              scr_q, scr_d;
  logic              cp_pend_q, cp_pend_d;
  logic [ADDR_W-1:0] rd_addr_q;
  logic [CELL_W-1:0] rd_data_q;
  logic [CELL_W-1:0] mem [CELLS];

  step_req_t         req;
  logic [CUR_W-1:0]  sum;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] blank;
  logic              start_scroll;
  logic              finish;
  logic              sweep_last;

  tcw_step_unit u_step (
    .req_i (req),
    .sum_o (sum)
  );

  assign blank      = {attr_i, CH_SPACE};
  assign sweep_last = (sweep_q == CUR_W'(CELLS - 1));

  always_comb begin
    state_d      = state_q;
    cursor_d     = cursor_q;
    row_start_d  = row_start_q;
    col_d        = col_q;
    sweep_d      = sweep_q;
    stop_d       = stop_q;
    item_d       = item_q;
    pend_d       = pend_q;
    upd_d        = upd_q;
    scr_d        = scr_q;
    cp_pend_d    = 1'b0;
    req          = '{kind: STEP_INC, operand: sweep_q};
    rd_en        = 1'b0;
    rd_addr      = sweep_q[ADDR_W-1:0];
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    start_scroll = 1'b0;
    finish       = 1'b0;
    // copy data read last cycle lands one row up
    we           = cp_pend_q;
    waddr        = rd_addr_q - ADDR_W'(COLUMNS);
    wdata        = rd_data_q;

    case (state_q)
      ST_INIT: begin
        we      = 1'b1;
        waddr   = sweep_q[ADDR_W-1:0];
        wdata   = RESET_CELL;
        sweep_d = sum;
        if (sweep_last) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        res_valid_o  = pend_q;
        if (pend_q && res_ready_i) begin
          pend_d = 1'b0;
        end
        item_ready_o = !pend_q || res_ready_i;
        req          = '{kind: STEP_ADD_FOUR, operand: cursor_q};
        if (item_valid_i && item_ready_o) begin
          item_d = item_i;
          stop_d = sum & ALIGN4_MASK;
          upd_d  = item_i.eos || item_i.op_clear;
          scr_d  = 1'b0;
          if (item_i.op_clear) begin
            cursor_d    = '0;
            row_start_d = '0;
            col_d       = '0;
            sweep_d     = '0;
            state_d     = ST_CLEAR;
          end else if (item_i.char_code == CH_TAB) begin
            state_d = ST_TAB;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        case (item_q.char_code)
          CH_NEWLINE: begin
            req = '{kind: STEP_ADD_COLS, operand: row_start_q};
            if (sum == CUR_W'(CELLS)) begin
              start_scroll = 1'b1;
            end else begin
              cursor_d    = sum;
              row_start_d = sum;
              col_d       = '0;
              finish      = 1'b1;
            end
          end
          CH_BACKSPACE: begin
            req = '{kind: STEP_DEC, operand: cursor_q};
            if (cursor_q != '0) begin
              cursor_d = sum;
              we       = 1'b1;
              waddr    = sum[ADDR_W-1:0];
              wdata    = blank;
              if (col_q == '0) begin
                col_d       = COL_W'(COLUMNS - 1);
                row_start_d = row_start_q - CUR_W'(COLUMNS);
              end else begin
                col_d = col_q - COL_W'(1);
              end
            end
            finish = 1'b1;
          end
          default: begin
            req      = '{kind: STEP_INC, operand: cursor_q};
            we       = 1'b1;
            waddr    = cursor_q[ADDR_W-1:0];
            wdata    = {attr_i, item_q.char_code};
            cursor_d = sum;
            if (col_q == COL_W'(COLUMNS - 1)) begin
              col_d       = '0;
              row_start_d = sum;
            end else begin
              col_d = col_q + COL_W'(1);
            end
            if (sum == CUR_W'(CELLS)) begin
              start_scroll = 1'b1;
            end else begin
              finish = 1'b1;
            end
          end
        endcase
      end
      ST_TAB: begin
        req      = '{kind: STEP_INC, operand: cursor_q};
        we       = 1'b1;
        waddr    = cursor_q[ADDR_W-1:0];
        wdata    = blank;
        cursor_d = sum;
        if (col_q == COL_W'(COLUMNS - 1)) begin
          col_d       = '0;
          row_start_d = sum;
        end else begin
          col_d = col_q + COL_W'(1);
        end
        if (sum == CUR_W'(CELLS)) begin
          start_scroll = 1'b1;
        end else if (sum == stop_q) begin
          finish = 1'b1;
        end
      end
      ST_COPY: begin
        rd_en     = 1'b1;
        cp_pend_d = 1'b1;
        sweep_d   = sum;
        if (sweep_last) begin
          sweep_d = CUR_W'(LAST_ROW_START);
          state_d = ST_BLANK;
        end
      end
      ST_BLANK: begin
        // the last copy write drains before the bottom row is blanked
        if (!cp_pend_q) begin
          we      = 1'b1;
          waddr   = sweep_q[ADDR_W-1:0];
          wdata   = blank;
          sweep_d = sum;
          if (sweep_last) begin
            finish = 1'b1;
          end
        end
      end
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = sweep_q[ADDR_W-1:0];
        wdata   = blank;
        sweep_d = sum;
        if (sweep_last) begin
          finish = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (start_scroll) begin
      cursor_d    = CUR_W'(LAST_ROW_START);
      row_start_d = CUR_W'(LAST_ROW_START);
      col_d       = '0;
      scr_d       = 1'b1;
      sweep_d     = CUR_W'(COLUMNS);
      state_d     = ST_COPY;
    end
    if (finish) begin
      pend_d  = 1'b1;
      state_d = ST_IDLE;
    end
  end

  assign res_o = '{cursor: cursor_q, update: upd_q, scrolled: scr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cursor_q    <= '0;
      row_start_q <= '0;
      col_q       <= '0;
      sweep_q     <= '0;
      pend_q      <= 1'b0;
      cp_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      row_start_q <= row_start_d;
      col_q       <= col_d;
      sweep_q     <= sweep_d;
      pend_q      <= pend_d;
      cp_pend_q   <= cp_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stop_q <= stop_d;
    item_q <= item_d;
    upd_q  <= upd_d;
    scr_q  <= scr_d;
  end

  // screen store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q < CUR_W'(CELLS))
    else $error("cursor beyond last cell");

  a_cursor_tracks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q == row_start_q + CUR_W'(col_q))
    else $error("cursor out of step with row start and column");

  a_copy_from_lower_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_pend_q |-> rd_addr_q >= ADDR_W'(COLUMNS))
    else $error("scroll copy source in top row");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_i && item_ready_o) |=> state_q != ST_IDLE)
    else $error("sequencer idle right after taking an item");

endmodule

// ----- rtl/core/text_console_writer.sv -----
// text console writer: an 80x25 screen of 16-bit cells (background, foreground,
// character) plus a linear cursor, driven by a character stream
//
// input stream: tdata carries the character, tuser selects put (0) or clear (1),
// tlast marks the last character of a string. output stream: one transaction per
// input item with the cursor index after the item, a cursor-update flag and a
// scrolled flag. the user writes colours via a plain port (index 0 foreground,
// index 1 background) while the block is idle; the block does not enforce this
//
// processing: a printable character, newline or backspace goes through the
// execute state; a tab blanks cells up to the next multiple of 4. the sequencer
// has one step unit and the screen store a single write port. a scroll moves
// rows 1 to 24 up one row, one cell per cycle, then blanks the bottom row;
// a clear sweeps all CELLS entries
//
// reset: the screen store is swept to white-on-black spaces with s_axis_tready
// low; config writes are taken during the sweep
// stalls: a finished result sits in the output register while the next item is
// taken; a second result waits inside until m_axis_tready frees the register
module text_console_writer
  import tcw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [CHAR_W-1:0]    s_axis_tdata,   // [7:0] char_code
  input  logic                 s_axis_tuser,   // [0] op
  input  logic                 s_axis_tlast,   // end_of_string
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [10:0] cursor_position, rest zero
  output logic [1:0]           m_axis_tuser,   // [0] cursor_update, [1] scrolled
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COLOUR_W-1:0]  cfg_data_i
);

  logic [COLOUR_W-1:0] fg_q;
  logic [COLOUR_W-1:0] bg_q;
  item_t               item;
  logic                res_valid;
  logic                res_ready;
  result_t             res;
  logic                out_valid_q;
  logic [POS_W-1:0]    out_pos_q;
  logic                out_upd_q;
  logic                out_scr_q;

  // colour registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_FG:  fg_q <= cfg_data_i;
        REG_BG:  bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign item = '{op_clear:  (op_e'(s_axis_tuser) == OP_CLEAR),
                  char_code: s_axis_tdata,
                  eos:       s_axis_tlast};

  tcw_sequencer u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s_axis_tvalid),
    .item_i       (item),
    .item_ready_o (s_axis_tready),
    .attr_i       ({bg_q, fg_q}),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // output register: refills in the cycle the receiver takes the previous one
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_pos_q <= POS_W'(res.cursor);
      out_upd_q <= res.update;
      out_scr_q <= res.scrolled;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - POS_W){1'b0}}, out_pos_q};
  assign m_axis_tuser  = {out_scr_q, out_upd_q};

endmodule
